// File: src/smsrch_pkg.sv
//------------------------------------------------------------------------------
// smsrch_pkg: shared types and constants of the sorted matrix search block
// Opcodes, register indexes, field layout of the stream items and the
// sequencer state type.
//------------------------------------------------------------------------------
`default_nettype none

package smsrch_pkg;

    // Operation carried in tuser of an input item.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CNT_W     = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 8'd1;

    // Input item field widths and packing in tdata, lowest bits first.
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned ROW_LSB    = 0;
    localparam int unsigned COL_LSB    = ROW_LSB + IDX_W;
    localparam int unsigned ENTRY_LSB  = COL_LSB + IDX_W;
    localparam int unsigned KEY_LSB    = ENTRY_LSB + VAL_W;
    localparam int unsigned IN_TDATA_W = 80;

    // Result item: the found flag sits alone in the low bit of a byte.
    localparam int unsigned OUT_TDATA_W = 8;

    // Search sequencer.
    typedef enum logic [1:0] {
        S_IDLE,     // takes items; a search issues its first row read here
        S_RFIRST,   // first entry of the probed row is on the read port
        S_RLAST,    // last entry of the probed row is on the read port
        S_CCMP      // probed entry of the chosen row is on the read port
    } t_state;

endpackage

`default_nettype wire

// File: src/smsrch_store.sv
//------------------------------------------------------------------------------
// smsrch_store: matrix entry memory
// One write port and one read port addressed by row and column, with the
// read data registered.
//------------------------------------------------------------------------------
`default_nettype none

module smsrch_store #(
    parameter int unsigned ROW_W      = 7,
    parameter int unsigned COL_W      = 7,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [ROW_W-1:0]      i_wr_row,
    input  wire logic [COL_W-1:0]      i_wr_col,
    input  wire logic [DATA_WIDTH-1:0] i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [ROW_W-1:0]      i_rd_row,
    input  wire logic [COL_W-1:0]      i_rd_col,
    output logic      [DATA_WIDTH-1:0] o_rd_data
);

    localparam int unsigned DEPTH = 2 ** (ROW_W + COL_W);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[{i_wr_row, i_wr_col}] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[{i_rd_row, i_rd_col}];
        end
    end

endmodule

`default_nettype wire

// File: src/sorted_matrix_search.sv
//------------------------------------------------------------------------------
// sorted_matrix_search: two-level binary search over a sorted matrix
// Holds a row-major matrix of signed words, rows sorted and rising from row
// to row, and answers whether a key is present.
//------------------------------------------------------------------------------
//
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser opcode, tdata row/col/entry/key
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata found
// cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// A load item writes one entry of the store. A search item runs row
// probes first. A row probe stops at the first entry of the row when it
// lies above the key, else it goes on to read the last entry as well. The
// row whose last entry is at or above the key is then searched by column
// probes, one read each. Probes run one after the other, set by the
// single read port of the store and the one shared comparator.
// The store has no reset; reset only clears the sequencer, the result valid
// flag and the two counts (both back to one).
// While a search runs the input is not ready. A finished result waits in
// its register; loads are still taken then, a new search waits for it.
//
`default_nettype none

module sorted_matrix_search #(
    parameter int unsigned MAX_ROWS   = 128,
    parameter int unsigned MAX_COLS   = 128,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // tdata, lowest bit up: row_index[6:0], col_index[13:7],
    // entry_value[45:14], search_key[77:46], zero fill[79:78]
    input  wire logic [smsrch_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: opcode
    input  wire logic                                 i_s_axis_tuser,

    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // tdata, lowest bit up: found[0], zero fill[7:1]
    output logic      [smsrch_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,

    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [smsrch_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [smsrch_pkg::CNT_W-1:0]         i_cfg_data
);

    // Address widths of the store and widths of the search bounds, which
    // must also hold the row or column count itself.
    localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CCW = $clog2(MAX_COLS + 1);
    localparam int unsigned BW  = (RCW > CCW) ? RCW : CCW;

    localparam int unsigned IDX_W = smsrch_pkg::IDX_W;
    localparam int unsigned VAL_W = smsrch_pkg::VAL_W;

    // Field extraction.
    logic [IDX_W-1:0] in_row;
    logic [IDX_W-1:0] in_col;
    logic [VAL_W-1:0] in_entry;
    logic [VAL_W-1:0] in_key;
    logic [63:0]      entry_ext;
    logic [63:0]      key_ext;

    assign in_row   = i_s_axis_tdata[smsrch_pkg::ROW_LSB +: IDX_W];
    assign in_col   = i_s_axis_tdata[smsrch_pkg::COL_LSB +: IDX_W];
    assign in_entry = i_s_axis_tdata[smsrch_pkg::ENTRY_LSB +: VAL_W];
    assign in_key   = i_s_axis_tdata[smsrch_pkg::KEY_LSB +: VAL_W];

    // The 32-bit fields are sign-extended and then cut to the data width,
    // so entries and key are both two's complement words of DATA_WIDTH bits.
    assign entry_ext = {{(64 - VAL_W){in_entry[VAL_W-1]}}, in_entry};
    assign key_ext   = {{(64 - VAL_W){in_key[VAL_W-1]}}, in_key};

    // Registers.
    smsrch_pkg::t_state    r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic                  r_found, n_found;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [BW-1:0]         r_lo, n_lo;
    logic [BW-1:0]         r_hi, n_hi;
    logic [BW-1:0]         r_mid, n_mid;
    logic [RW-1:0]         r_row, n_row;
    logic [smsrch_pkg::CNT_W-1:0] r_row_count;
    logic [smsrch_pkg::CNT_W-1:0] r_col_count;

    // Handshakes.
    logic in_accept;
    logic load_accept;
    logic search_accept;
    logic load_in_range;

    assign o_s_axis_tready = (r_state == smsrch_pkg::S_IDLE) &&
                             ((i_s_axis_tuser == smsrch_pkg::OP_LOAD) || !r_out_valid);
    assign in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign load_accept   = in_accept && (i_s_axis_tuser == smsrch_pkg::OP_LOAD);
    assign search_accept = in_accept && (i_s_axis_tuser == smsrch_pkg::OP_SEARCH);

    // Loads beyond the store are dropped.
    assign load_in_range = (32'(in_row) < 32'(MAX_ROWS)) && (32'(in_col) < 32'(MAX_COLS));

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(smsrch_pkg::OUT_TDATA_W - 1){1'b0}}, r_found};

    // Counts in use, saturated to the store size.
    logic [RCW-1:0] rows_use;
    logic [CCW-1:0] cols_use;
    logic [CCW-1:0] col_last_w;
    logic [CW-1:0]  col_last;
    logic           empty;

    assign rows_use   = (32'(r_row_count) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                                                           : RCW'(r_row_count);
    assign cols_use   = (32'(r_col_count) > 32'(MAX_COLS)) ? CCW'(MAX_COLS)
                                                           : CCW'(r_col_count);
    assign col_last_w = cols_use - CCW'(1);
    assign col_last   = col_last_w[CW-1:0];
    assign empty      = (rows_use == '0) || (cols_use == '0);

    // Store.
    logic                  rd_en;
    logic [RW-1:0]         rd_row;
    logic [CW-1:0]         rd_col;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  wr_en;

    assign wr_en = load_accept && load_in_range;

    smsrch_store #(
        .ROW_W      (RW),
        .COL_W      (CW),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_row  (RW'(in_row)),
        .i_wr_col  (CW'(in_col)),
        .i_wr_data (entry_ext[DATA_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .i_rd_col  (rd_col),
        .o_rd_data (rd_data)
    );

    // The one comparator: the entry just read against the key.
    logic cmp_gt;
    logic cmp_eq;
    logic cmp_lt;

    assign cmp_gt = $signed(rd_data) > $signed(r_key);
    assign cmp_eq = rd_data == r_key;
    assign cmp_lt = !cmp_gt && !cmp_eq;

    // New search bounds for this cycle and the midpoint that the next
    // probe reads. A probe happens only while the bounds are not empty.
    logic [BW-1:0] bnd_lo;
    logic [BW-1:0] bnd_hi;
    logic [BW-1:0] mid_c;
    logic          go;

    always_comb begin
        bnd_lo = r_lo;
        bnd_hi = r_hi;
        unique case (r_state)
            smsrch_pkg::S_IDLE: begin
                bnd_lo = '0;
                bnd_hi = BW'(rows_use);
            end
            smsrch_pkg::S_RFIRST: begin
                // First entry above the key: the row lies below the midpoint.
                if (cmp_gt) begin
                    bnd_hi = r_mid;
                end
            end
            smsrch_pkg::S_RLAST: begin
                // Last entry at or above the key: this row covers it, and
                // the column search starts over the whole row.
                if (!cmp_lt) begin
                    bnd_lo = '0;
                    bnd_hi = BW'(cols_use);
                end else begin
                    bnd_lo = r_mid + BW'(1);
                end
            end
            smsrch_pkg::S_CCMP: begin
                if (cmp_gt) begin
                    bnd_hi = r_mid;
                end else begin
                    bnd_lo = r_mid + BW'(1);
                end
            end
            default: begin
                bnd_lo = r_lo;
                bnd_hi = r_hi;
            end
        endcase
        go    = bnd_lo < bnd_hi;
        mid_c = bnd_lo + ((bnd_hi - bnd_lo) >> 1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smsrch_pkg::S_IDLE: begin
                if (search_accept && !empty) begin
                    n_state = smsrch_pkg::S_RFIRST;
                end
            end
            smsrch_pkg::S_RFIRST: begin
                if (!cmp_gt) begin
                    n_state = smsrch_pkg::S_RLAST;
                end else if (!go) begin
                    n_state = smsrch_pkg::S_IDLE;
                end
            end
            smsrch_pkg::S_RLAST: begin
                if (!cmp_lt) begin
                    n_state = smsrch_pkg::S_CCMP;
                end else if (go) begin
                    n_state = smsrch_pkg::S_RFIRST;
                end else begin
                    n_state = smsrch_pkg::S_IDLE;
                end
            end
            smsrch_pkg::S_CCMP: begin
                if (cmp_eq || !go) begin
                    n_state = smsrch_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = smsrch_pkg::S_IDLE;
            end
        endcase
    end

    // Read requests, bound updates and the result.
    always_comb begin
        rd_en       = 1'b0;
        rd_row      = r_row;
        rd_col      = '0;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_row       = r_row;
        n_key       = r_key;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        unique case (r_state)
            smsrch_pkg::S_IDLE: begin
                if (search_accept) begin
                    n_key = key_ext[DATA_WIDTH-1:0];
                    if (empty) begin
                        n_found     = 1'b0;
                        n_out_valid = 1'b1;
                    end else begin
                        rd_en  = 1'b1;
                        rd_row = mid_c[RW-1:0];
                        n_lo   = bnd_lo;
                        n_hi   = bnd_hi;
                        n_mid  = mid_c;
                    end
                end
            end
            smsrch_pkg::S_RFIRST: begin
                if (!cmp_gt) begin
                    rd_en  = 1'b1;
                    rd_row = r_mid[RW-1:0];
                    rd_col = col_last;
                end else if (go) begin
                    rd_en  = 1'b1;
                    rd_row = mid_c[RW-1:0];
                    n_lo   = bnd_lo;
                    n_hi   = bnd_hi;
                    n_mid  = mid_c;
                end else begin
                    n_found     = 1'b0;
                    n_out_valid = 1'b1;
                end
            end
            smsrch_pkg::S_RLAST: begin
                if (!cmp_lt) begin
                    rd_en  = 1'b1;
                    rd_row = r_mid[RW-1:0];
                    rd_col = mid_c[CW-1:0];
                    n_row  = r_mid[RW-1:0];
                    n_lo   = bnd_lo;
                    n_hi   = bnd_hi;
                    n_mid  = mid_c;
                end else if (go) begin
                    rd_en  = 1'b1;
                    rd_row = mid_c[RW-1:0];
                    n_lo   = bnd_lo;
                    n_hi   = bnd_hi;
                    n_mid  = mid_c;
                end else begin
                    n_found     = 1'b0;
                    n_out_valid = 1'b1;
                end
            end
            smsrch_pkg::S_CCMP: begin
                if (cmp_eq) begin
                    n_found     = 1'b1;
                    n_out_valid = 1'b1;
                end else if (go) begin
                    rd_en  = 1'b1;
                    rd_row = r_row;
                    rd_col = mid_c[CW-1:0];
                    n_lo   = bnd_lo;
                    n_hi   = bnd_hi;
                    n_mid  = mid_c;
                end else begin
                    n_found     = 1'b0;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smsrch_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_row   <= n_row;
    end

    // Configuration: unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= smsrch_pkg::CNT_W'(1);
            r_col_count <= smsrch_pkg::CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == smsrch_pkg::REG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end else if (i_cfg_index == smsrch_pkg::REG_COL_COUNT) begin
                r_col_count <= i_cfg_data;
            end
        end
    end

    // Assertions.
    a_probe_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != smsrch_pkg::S_IDLE) |-> (r_lo <= r_mid) && (r_mid < r_hi))
        else $error("probe midpoint outside the search bounds");

    a_row_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsrch_pkg::S_RFIRST || r_state == smsrch_pkg::S_RLAST)
        |-> (32'(r_mid) < 32'(rows_use)))
        else $error("row probe beyond the rows in use");

    a_col_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsrch_pkg::S_CCMP) |-> (32'(r_mid) < 32'(cols_use)))
        else $error("column probe beyond the columns in use");

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == smsrch_pkg::S_IDLE))
        else $error("result raised while a search is still running");

    a_read_write_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !wr_en)
        else $error("store read and write in the same cycle");

endmodule

`default_nettype wire
